[sv/ssq_pkg.sv]
// ---------------------------------------------------------------------------
// ssq_pkg: shared types and constants for the step sequencer
// Holds the input and result word layouts, the queued record layout and the
// control and status bundles passed between the sequencer and its queue.
// ---------------------------------------------------------------------------
package ssq_pkg;

    localparam int NUM_AXES = 3;

    // Function codes carried in the input word.
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_PUSH = 1'b1;

    // One input word.
    typedef struct packed {
        logic        func;
        logic [15:0] period;
        logic [2:0]  step_mask;
        logic [2:0]  flip_mask;
        logic [2:0]  start_dirs;
        logic        first_of_motion;
        logic        pause;
    } ssq_in_t;

    // One result word.
    typedef struct packed {
        logic [2:0]   step_pins;
        logic [2:0]   dir_pins;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic         accepted;
        logic         stepped;
        logic         busy_res;
    } ssq_out_t;

    // One queued step record.
    typedef struct packed {
        logic [15:0] period;
        logic [2:0]  step_mask;
        logic [2:0]  flip_mask;
        logic [2:0]  start_dirs;
        logic        first;
    } ssq_rec_t;

    // Requests from the sequencer to the queue.
    typedef struct packed {
        logic     push;
        logic     pop;
        ssq_rec_t wdata;
    } ssq_qctl_t;

    // Queue status seen by the sequencer.
    typedef struct packed {
        logic     empty;
        logic     full;
        logic     single;
        ssq_rec_t head;
    } ssq_qstat_t;

endpackage

[sv/ssq_ram.sv]
// ---------------------------------------------------------------------------
// ssq_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
module ssq_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/ssq_queue.sv]
// ---------------------------------------------------------------------------
// ssq_queue: step record queue with a registered head entry
// Records live in a RAM ring. The head record is also held in a register so
// that it can be used and replaced in every cycle; the RAM is always reading
// the entry behind the head, with a bypass for a write to that same entry.
// ---------------------------------------------------------------------------
module ssq_queue import ssq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  ssq_qctl_t  ctl,
    output ssq_qstat_t stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int REC_W = $bits(ssq_rec_t);

    logic [PTR_W-1:0] head_ptr_reg, head_ptr_next;
    logic [PTR_W-1:0] tail_ptr_reg, tail_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    ssq_rec_t         head_reg, head_next;
    logic             byp_valid_reg, byp_valid_next;
    ssq_rec_t         byp_data_reg;
    logic [PTR_W-1:0] rd_addr;
    logic [REC_W-1:0] rd_data;
    ssq_rec_t         behind_head;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    ssq_ram #(
        .WIDTH(REC_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ctl.push),
        .waddr(tail_ptr_reg),
        .wdata(ctl.wdata),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    // The RAM looks one entry past the head the queue will have next cycle.
    assign rd_addr     = ctl.pop ? ptr_inc(ptr_inc(head_ptr_reg)) : ptr_inc(head_ptr_reg);
    assign behind_head = byp_valid_reg ? byp_data_reg : ssq_rec_t'(rd_data);

    // Pointer, count and head register updates.
    always_comb begin
        head_ptr_next  = head_ptr_reg;
        tail_ptr_next  = tail_ptr_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        byp_valid_next = ctl.push && (tail_ptr_reg == rd_addr);
        if (ctl.push) begin
            tail_ptr_next = ptr_inc(tail_ptr_reg);
            count_next    = count_reg + 1'b1;
            if (count_reg == '0) begin
                head_next = ctl.wdata;
            end
        end else if (ctl.pop) begin
            head_ptr_next = ptr_inc(head_ptr_reg);
            count_next    = count_reg - 1'b1;
            head_next     = behind_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_ptr_reg  <= '0;
            tail_ptr_reg  <= '0;
            count_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end else begin
            head_ptr_reg  <= head_ptr_next;
            tail_ptr_reg  <= tail_ptr_next;
            count_reg     <= count_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg     <= head_next;
        byp_data_reg <= ctl.wdata;
    end

    assign stat.empty  = (count_reg == '0);
    assign stat.full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.single = (count_reg == CNT_W'(1));
    assign stat.head   = head_reg;

endmodule

[sv/ssq_skid.sv]
// ---------------------------------------------------------------------------
// ssq_skid: two-entry result buffer
// Holds the result word for the receiver and one more in a skid register,
// so the sequencer can take one more word while a result waits.
// ---------------------------------------------------------------------------
module ssq_skid import ssq_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  ssq_out_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output ssq_out_t out_data
);

    logic     out_valid_reg, out_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    ssq_out_t out_data_reg, out_data_next;
    ssq_out_t skid_data_reg, skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Refill the output slot when it frees, else park the new word.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end else if (in_valid && in_ready) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

[sv/stepper_step_sequencer_unit.sv]
// ---------------------------------------------------------------------------
// stepper_step_sequencer_unit: three-axis stepper step pulse sequencer
// Queues step records and plays them out against a tick count.
// ---------------------------------------------------------------------------
// Usage:
// The s_ channel takes one word per cycle while s_ready is high: either a
// timer tick or a push of one step record into the record queue. Every
// accepted word gives exactly one result word on the m_ channel with the
// step and direction levels, the three axis positions and the accepted,
// stepped and busy flags after it, registered in the result buffer.
// Throughput is one word per cycle while s_ready is high: the sequencer
// state, the head record register and the queue RAM all update together,
// and the queue RAM keeps the entry behind the head read ahead so
// back-to-back steps need no stall. When the receiver stalls, one more
// word is taken into a skid register and s_ready then drops until the
// receiver takes a result. Reset clears the queue count, counter, period,
// levels and positions at once; the queue RAM needs no clearing pass, and
// words are taken as soon as reset is released.
// ---------------------------------------------------------------------------
module stepper_step_sequencer_unit import ssq_pkg::*; #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int POSITION_WIDTH = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ssq_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ssq_out_t m_data
);

    localparam int POS_W = POSITION_WIDTH;

    logic             accept;
    logic             is_push;
    ssq_qctl_t        qctl;
    ssq_qstat_t       qstat;
    ssq_out_t         result;
    logic             stepped;
    logic             pop_req;
    logic             busy;
    logic [2:0]       dir_base;

    logic [15:0]      tick_cnt_reg, tick_cnt_next;
    logic [15:0]      period_reg, period_next;
    logic             running_reg, running_next;
    logic [2:0]       step_reg, step_next;
    logic [2:0]       dir_reg, dir_next;
    logic [POS_W-1:0] pos_reg [NUM_AXES];
    logic [POS_W-1:0] pos_next [NUM_AXES];

    assign accept  = s_valid && s_ready;
    assign is_push = (s_data.func == FUNC_PUSH);

    // Record write into the queue.
    assign qctl.push             = accept && is_push && !qstat.full;
    assign qctl.pop              = pop_req;
    assign qctl.wdata.period     = s_data.period;
    assign qctl.wdata.step_mask  = s_data.step_mask;
    assign qctl.wdata.flip_mask  = s_data.flip_mask;
    assign qctl.wdata.start_dirs = s_data.start_dirs;
    assign qctl.wdata.first      = s_data.first_of_motion;

    ssq_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (qctl),
        .stat   (qstat)
    );

    // Tick handling: idle start, count up, at match run head or go idle.
    assign dir_base = qstat.head.first ? qstat.head.start_dirs : dir_reg;

    always_comb begin
        tick_cnt_next = tick_cnt_reg;
        period_next   = period_reg;
        running_next  = running_reg;
        step_next     = step_reg;
        dir_next      = dir_reg;
        stepped       = 1'b0;
        pop_req       = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            pos_next[a] = pos_reg[a];
        end
        if (accept && !is_push) begin
            if (!running_reg) begin
                if (!qstat.empty) begin
                    period_next   = qstat.head.period;
                    tick_cnt_next = '0;
                    running_next  = 1'b1;
                end
            end else if (tick_cnt_reg != period_reg) begin
                tick_cnt_next = tick_cnt_reg + 1'b1;
            end else if (!s_data.pause) begin
                if (!qstat.empty) begin
                    pop_req   = 1'b1;
                    stepped   = 1'b1;
                    step_next = step_reg ^ qstat.head.step_mask;
                    for (int a = 0; a < NUM_AXES; a++) begin
                        if (qstat.head.step_mask[a]) begin
                            pos_next[a] = pos_reg[a] +
                                (dir_base[a] ? POS_W'(1) : {POS_W{1'b1}});
                        end
                    end
                    dir_next      = dir_base ^ qstat.head.flip_mask;
                    period_next   = qstat.head.period;
                    tick_cnt_next = '0;
                end else begin
                    running_next  = 1'b0;
                    tick_cnt_next = '0;
                end
            end
        end
    end

    // Busy after this word: running, or the queue still holds a record.
    assign busy = running_next || qctl.push || !(qstat.empty || (qstat.single && qctl.pop));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_cnt_reg <= '0;
            period_reg   <= '0;
            running_reg  <= 1'b0;
            step_reg     <= '0;
            dir_reg      <= '0;
            for (int a = 0; a < NUM_AXES; a++) begin
                pos_reg[a] <= '0;
            end
        end else begin
            tick_cnt_reg <= tick_cnt_next;
            period_reg   <= period_next;
            running_reg  <= running_next;
            step_reg     <= step_next;
            dir_reg      <= dir_next;
            for (int a = 0; a < NUM_AXES; a++) begin
                pos_reg[a] <= pos_next[a];
            end
        end
    end

    // Result word, positions sign-extended or cut to 32 bits.
    assign result.step_pins = step_next;
    assign result.dir_pins  = dir_next;
    assign result.pos_x     = 32'(signed'(pos_next[0]));
    assign result.pos_y     = 32'(signed'(pos_next[1]));
    assign result.pos_z     = 32'(signed'(pos_next[2]));
    assign result.accepted  = qctl.push;
    assign result.stepped   = stepped;
    assign result.busy_res  = busy;

    ssq_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (accept),
        .in_ready (s_ready),
        .in_data  (result),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_data (m_data)
    );

endmodule

[sv/ssq_checker.sv]
// ---------------------------------------------------------------------------
// ssq_checker: port-level checks for the step sequencer
// Watches the result channel for flag combinations the sequencer can never
// produce, a held result under stall and a result shown right after reset.
// ---------------------------------------------------------------------------
module ssq_checker import ssq_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input ssq_out_t m_data
);

    // A stalled result stays in place.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // A word is either a stored push or an executed step, never both.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.accepted && m_data.stepped))
        else $error("accepted and stepped both set");

    // A stored record or a step leaves the sequencer busy.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.accepted || m_data.stepped) |-> m_data.busy_res)
        else $error("busy low after push or step");

    // No result is shown right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind stepper_step_sequencer_unit ssq_checker u_ssq_checker (.*);

[bench/stepper_seq_checker.sv]
// ---------------------------------------------------------------------------
// stepper_seq_checker: result predictor and comparator for the step sequencer
// Watches both channels of the sequencer. Every word taken on the s_ side is
// run through a cycle-free model of the record queue, tick counter, levels
// and positions, and the status it should produce is queued. Every word
// taken on the m_ side is compared field by field with the oldest queued
// status. Errors are counted and handed to the testbench top.
// ---------------------------------------------------------------------------
module stepper_seq_checker import ssq_pkg::*; #(
    parameter int REC_SLOTS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  ssq_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  ssq_out_t m_data,
    output int       errors,
    output int       backlog
);

    // Model state of the sequencer.
    ssq_rec_t           rec_fifo [$];
    logic [15:0]        ticks;
    logic [15:0]        cur_period;
    logic               timer_on;
    logic [2:0]         step_lv;
    logic [2:0]         dir_lv;
    logic signed [31:0] axis_pos [NUM_AXES];

    // Status words still owed by the sequencer, oldest first.
    ssq_out_t awaited_status [$];

    // Prints one line per bad field and counts it.
    task automatic report_error(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
        errors++;
    endtask

    // Applies one input word to the model and returns the status after it.
    function automatic ssq_out_t next_status(input ssq_in_t w);
        ssq_out_t o;
        ssq_rec_t r;
        logic     took;
        logic     fired;
        took  = 1'b0;
        fired = 1'b0;
        if (w.func == FUNC_PUSH) begin
            // A full queue refuses the record and stays as it is.
            if (rec_fifo.size() < REC_SLOTS) begin
                r.period    = w.period;
                r.step_mask = w.step_mask;
                r.flip_mask = w.flip_mask;
                r.start_dirs = w.start_dirs;
                r.first     = w.first_of_motion;
                rec_fifo.push_back(r);
                took = 1'b1;
            end
        end else if (!timer_on) begin
            // Starting from idle, the head record first waits its own period.
            if (rec_fifo.size() > 0) begin
                cur_period = rec_fifo[0].period;
                ticks      = '0;
                timer_on   = 1'b1;
            end
        end else if (ticks != cur_period) begin
            ticks = ticks + 16'd1;
        end else if (!w.pause) begin
            if (rec_fifo.size() > 0) begin
                r = rec_fifo.pop_front();
                if (r.first) begin
                    dir_lv = r.start_dirs;
                end
                // Steps use the direction held before this record's flips.
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (r.step_mask[a]) begin
                        step_lv[a]  = ~step_lv[a];
                        axis_pos[a] = dir_lv[a] ? axis_pos[a] + 32'sd1
                                                : axis_pos[a] - 32'sd1;
                    end
                end
                dir_lv     = dir_lv ^ r.flip_mask;
                cur_period = r.period;
                ticks      = '0;
                fired      = 1'b1;
            end else begin
                // Match with nothing queued: the motion is over.
                timer_on = 1'b0;
                ticks    = '0;
            end
        end
        o.step_pins = step_lv;
        o.dir_pins  = dir_lv;
        o.pos_x     = axis_pos[0];
        o.pos_y     = axis_pos[1];
        o.pos_z     = axis_pos[2];
        o.accepted  = took;
        o.stepped   = fired;
        o.busy_res  = timer_on || (rec_fifo.size() > 0);
        return o;
    endfunction

    // Compare taken results first, then predict for the word taken at this edge.
    always @(posedge aclk) begin
        ssq_out_t got;
        ssq_out_t want;
        if (!aresetn) begin
            rec_fifo.delete();
            awaited_status.delete();
            ticks      = '0;
            cur_period = '0;
            timer_on   = 1'b0;
            step_lv    = '0;
            dir_lv     = '0;
            for (int a = 0; a < NUM_AXES; a++) begin
                axis_pos[a] = '0;
            end
            errors = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_status.size() == 0) begin
                    report_error("result word with nothing expected", '0, '0);
                end else begin
                    want = awaited_status.pop_front();
                    got  = m_data;
                    if (got.step_pins !== want.step_pins)
                        report_error("step_pins", 32'(got.step_pins),
                                     32'(want.step_pins));
                    if (got.dir_pins !== want.dir_pins)
                        report_error("dir_pins", 32'(got.dir_pins),
                                     32'(want.dir_pins));
                    if (got.pos_x !== want.pos_x)
                        report_error("pos_x", got.pos_x, want.pos_x);
                    if (got.pos_y !== want.pos_y)
                        report_error("pos_y", got.pos_y, want.pos_y);
                    if (got.pos_z !== want.pos_z)
                        report_error("pos_z", got.pos_z, want.pos_z);
                    if (got.accepted !== want.accepted)
                        report_error("accepted", 32'(got.accepted),
                                     32'(want.accepted));
                    if (got.stepped !== want.stepped)
                        report_error("stepped", 32'(got.stepped),
                                     32'(want.stepped));
                    if (got.busy_res !== want.busy_res)
                        report_error("busy_res", 32'(got.busy_res),
                                     32'(want.busy_res));
                end
            end
            if (s_valid && s_ready) begin
                awaited_status.push_back(next_status(s_data));
            end
        end
        backlog <= awaited_status.size();
    end

endmodule

[bench/stepper_step_sequencer_unit_tb.sv]
// ---------------------------------------------------------------------------
// stepper_step_sequencer_unit_tb: testbench for the step sequencer
// Sends a short directed run through idle start, pause, direction loading,
// flips, going idle and a full queue, then random motions made of short
// record bursts and tick runs, with random idle cycles on both channels.
// A separate checker predicts and compares every result word.
// ---------------------------------------------------------------------------
module stepper_step_sequencer_unit_tb;
    import ssq_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int POSITION_WIDTH = 32;
    localparam int RANDOM_WORDS   = 750;
    localparam int CYCLE_LIMIT    = 400000;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ssq_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ssq_out_t m_data;

    int errors;
    int backlog;
    int sent      = 0;
    int idle_mode = 1;
    int cycles    = 0;

    always #5 aclk = ~aclk;

    stepper_step_sequencer_unit #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .POSITION_WIDTH(POSITION_WIDTH)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    stepper_seq_checker #(
        .REC_SLOTS(QUEUE_DEPTH)
    ) u_checker (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data),
        .errors (errors),
        .backlog(backlog)
    );

    // Idle cycles before a word or a result: none, occasional, or heavy.
    function automatic int pick_wait();
        case (idle_mode)
            0: return 0;
            1: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 17) : 0;
            default: return $urandom_range(0, 17);
        endcase
    endfunction

    // Mostly very short periods so that records run often.
    function automatic logic [15:0] short_period();
        return ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 60))
                                           : 16'($urandom_range(0, 3));
    endfunction

    // A word of the given function with every other field random.
    function automatic ssq_in_t rand_word(input logic f);
        ssq_in_t w;
        w.func            = f;
        w.period          = 16'($urandom_range(0, 65535));
        w.step_mask       = 3'($urandom_range(0, 7));
        w.flip_mask       = 3'($urandom_range(0, 7));
        w.start_dirs      = 3'($urandom_range(0, 7));
        w.first_of_motion = 1'($urandom_range(0, 1));
        w.pause           = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // Presents one word after a random gap and holds it until it is taken.
    task automatic put_word(input ssq_in_t w);
        int gap;
        gap = pick_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sent++;
        if (sent % 40 == 0) begin
            idle_mode = $urandom_range(0, 2);
        end
    endtask

    // Receiver: after each result taken, stall for a random number of cycles.
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                hold = pick_wait();
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Run limit.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("stepper_step_sequencer_unit: mismatch");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        ssq_in_t w;
        int      pick;
        int      n;
        int      last;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Tick on an idle, empty sequencer.
        w = rand_word(FUNC_TICK);
        put_word(w);

        // First record of a motion: all axes step forward, pause ignored on push.
        w = rand_word(FUNC_PUSH);
        w.period = 16'd0; w.step_mask = 3'd7; w.flip_mask = 3'd0;
        w.start_dirs = 3'd7; w.first_of_motion = 1'b1; w.pause = 1'b1;
        put_word(w);
        // Follow-on record: keeps directions, then flips y.
        w = rand_word(FUNC_PUSH);
        w.period = 16'd1; w.step_mask = 3'd5; w.flip_mask = 3'd2;
        w.start_dirs = 3'd0; w.first_of_motion = 1'b0; w.pause = 1'b0;
        put_word(w);

        // Idle start even under pause, hold at match, then the first record, the
        // second record, a count and going idle on an empty queue.
        w = rand_word(FUNC_TICK); w.pause = 1'b1; put_word(w);
        w = rand_word(FUNC_TICK); w.pause = 1'b1; put_word(w);
        w = rand_word(FUNC_TICK); w.pause = 1'b0; put_word(w);
        w = rand_word(FUNC_TICK); w.pause = 1'b0; put_word(w);
        w = rand_word(FUNC_TICK); w.pause = 1'b0; put_word(w);
        w = rand_word(FUNC_TICK); w.pause = 1'b0; put_word(w);

        // Fill the queue with every mask value.
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w = rand_word(FUNC_PUSH);
            w.period          = 16'(i);
            w.step_mask       = i[2:0];
            w.flip_mask       = ~i[2:0];
            w.start_dirs      = i[2:0] + 3'd3;
            w.first_of_motion = i[0];
            put_word(w);
        end
        // Push to a full queue with every field at its top value is refused.
        w = rand_word(FUNC_PUSH);
        w.period = 16'hFFFF; w.step_mask = 3'd7; w.flip_mask = 3'd7;
        w.start_dirs = 3'd7; w.first_of_motion = 1'b1; w.pause = 1'b1;
        put_word(w);

        // Random motions, tick runs and push floods.
        last = sent + RANDOM_WORDS;
        while (sent < last) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                // A motion: mostly well formed, a first record then followers.
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++) begin
                    w = rand_word(FUNC_PUSH);
                    w.period = short_period();
                    w.first_of_motion = (k == 0) ? ($urandom_range(0, 7) != 0)
                                                 : ($urandom_range(0, 7) == 0);
                    put_word(w);
                end
            end else if (pick < 88) begin
                n = $urandom_range(1, 30);
                for (int k = 0; k < n; k++) begin
                    w = rand_word(FUNC_TICK);
                    w.pause = ($urandom_range(0, 5) == 0);
                    put_word(w);
                end
            end else begin
                n = $urandom_range(1, 18);
                for (int k = 0; k < n; k++) begin
                    w = rand_word(FUNC_PUSH);
                    w.period = short_period();
                    put_word(w);
                end
            end
        end
        s_valid <= 1'b0;

        // Drain the outstanding results, then a few quiet cycles.
        @(posedge aclk);
        while (backlog != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (errors == 0) begin
            $display("stepper_step_sequencer_unit: match");
        end else begin
            $display("stepper_step_sequencer_unit: mismatch");
        end
        $finish;
    end

endmodule
